// ===== rtl/srfp_pkg.sv =====
// Shared types and constants for the sonar reply frame parser.
`timescale 1ns / 1ps

package srfp_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 512;
   localparam int POS_W = 10;
   localparam int LEN_W = 17;
   localparam int BIN_W = 9;

   localparam logic [7:0] HDR_BYTE = 8'h40;
   localparam logic [7:0] TERM_BYTE = 8'h0a;
   localparam logic [POS_W-1:0] FIRST_BIN_POS = 10'd44;
   localparam logic [LEN_W-1:0] LEN_OVERHEAD = 17'd6;
   localparam logic [BIN_W-1:0] BIN_SAT = 9'd511;

   localparam logic [POS_W-1:0] POS_LEN_LO = 10'd5;
   localparam logic [POS_W-1:0] POS_LEN_HI = 10'd6;
   localparam logic [POS_W-1:0] POS_SRC = 10'd7;
   localparam logic [POS_W-1:0] POS_DST = 10'd8;
   localparam logic [POS_W-1:0] POS_COUNT = 10'd9;
   localparam logic [POS_W-1:0] POS_CODE = 10'd10;
   localparam logic [POS_W-1:0] POS_BEAR_LO = 10'd40;
   localparam logic [POS_W-1:0] POS_BEAR_HI = 10'd41;

   localparam logic [1:0] STATUS_GOOD = 2'd0;
   localparam logic [1:0] STATUS_BAD_TERM = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

   localparam logic CSR_HIT_THRESHOLD = 1'b0;
   localparam logic CSR_HEAD_DATA_CODE = 1'b1;

   typedef struct packed {
      logic [1:0]       frame_status;
      logic [7:0]       message_code;
      logic [7:0]       source_node;
      logic [7:0]       dest_node;
      logic [7:0]       msg_byte_count;
      logic             is_head_data;
      logic [15:0]      head_bearing;
      logic             hit_found;
      logic [BIN_W-1:0] first_hit_bin;
      logic [BIN_W-1:0] bin_total;
   } result_type;

endpackage

// ===== rtl/srfp_frame_core.sv =====
// Frame tracking state and per-byte decode logic of the reply parser.
`timescale 1ns / 1ps

module srfp_frame_core import srfp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic [7:0] hit_threshold,
   input  logic [7:0] head_data_code,
   output logic       result_valid,
   output result_type result
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

   logic             in_frame_ff, in_frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] exp_len_ff, exp_len_in;
   logic [7:0]       len_low_ff, len_low_in;
   logic [7:0]       src_ff, src_in;
   logic [7:0]       dst_ff, dst_in;
   logic [7:0]       count_ff, count_in;
   logic [7:0]       code_ff, code_in;
   logic [15:0]      bearing_ff, bearing_in;
   logic             hit_ff, hit_in;
   logic [BIN_W-1:0] hit_idx_ff, hit_idx_in;

   logic [POS_W-1:0] pos_next;
   logic [LEN_W-1:0] exp_cur;
   logic [POS_W-1:0] bin_off;
   logic [BIN_W-1:0] bin_sat;
   logic             good;
   logic             head;

   always_comb begin
      pos_next = pos_ff + 1'b1;
      exp_cur = (pos_next == POS_LEN_HI) ? ({1'b0, rx_byte, len_low_ff} + LEN_OVERHEAD)
                                         : exp_len_ff;
      bin_off = pos_next - FIRST_BIN_POS;
      bin_sat = (bin_off > POS_W'(BIN_SAT)) ? BIN_SAT : bin_off[BIN_W-1:0];
      good = (rx_byte == TERM_BYTE);
      head = good && (code_ff == head_data_code);

      in_frame_in = in_frame_ff;
      pos_in = pos_ff;
      exp_len_in = exp_len_ff;
      len_low_in = len_low_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      count_in = count_ff;
      code_in = code_ff;
      bearing_in = bearing_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      result_valid = 1'b0;
      result = '0;

      if (!in_frame_ff) begin
         if (rx_byte == HDR_BYTE) begin
            in_frame_in = 1'b1;
            pos_in = '0;
            exp_len_in = '0;
            len_low_in = '0;
            src_in = '0;
            dst_in = '0;
            count_in = '0;
            code_in = '0;
            bearing_in = '0;
            hit_in = 1'b0;
            hit_idx_in = '0;
         end
      end else begin
         pos_in = pos_next;
         exp_len_in = exp_cur;
         if (pos_next == POS_LEN_LO) begin
            len_low_in = rx_byte;
         end
         if ((pos_next == POS_LEN_HI) && (exp_cur > MAX_LEN)) begin
            result_valid = 1'b1;
            result.frame_status = STATUS_OVERSIZE;
            in_frame_in = 1'b0;
         end else if ((pos_next >= POS_LEN_HI) &&
                      ((LEN_W'(pos_next) + 1'b1) >= exp_cur)) begin
            result_valid = 1'b1;
            in_frame_in = 1'b0;
            result.frame_status = good ? STATUS_GOOD : STATUS_BAD_TERM;
            result.message_code = code_ff;
            result.source_node = src_ff;
            result.dest_node = dst_ff;
            result.msg_byte_count = count_ff;
            result.is_head_data = head;
            if (head) begin
               result.head_bearing = bearing_ff;
               result.hit_found = hit_ff;
               result.first_hit_bin = hit_ff ? hit_idx_ff : '0;
               result.bin_total = (pos_next > FIRST_BIN_POS) ? bin_sat : '0;
            end
         end else begin
            case (pos_next)
               POS_SRC:     src_in = rx_byte;
               POS_DST:     dst_in = rx_byte;
               POS_COUNT:   count_in = rx_byte;
               POS_CODE:    code_in = rx_byte;
               POS_BEAR_LO: bearing_in = {bearing_ff[15:8], rx_byte};
               POS_BEAR_HI: bearing_in = {rx_byte, bearing_ff[7:0]};
               default:     ;
            endcase
            if ((pos_next >= FIRST_BIN_POS) && !hit_ff && (rx_byte >= hit_threshold)) begin
               hit_in = 1'b1;
               hit_idx_in = bin_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff <= '0;
         exp_len_ff <= '0;
         len_low_ff <= '0;
         src_ff <= '0;
         dst_ff <= '0;
         count_ff <= '0;
         code_ff <= '0;
         bearing_ff <= '0;
         hit_ff <= 1'b0;
         hit_idx_ff <= '0;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         pos_ff <= pos_in;
         exp_len_ff <= exp_len_in;
         len_low_ff <= len_low_in;
         src_ff <= src_in;
         dst_ff <= dst_in;
         count_ff <= count_in;
         code_ff <= code_in;
         bearing_ff <= bearing_in;
         hit_ff <= hit_in;
         hit_idx_ff <= hit_idx_in;
      end
   end

endmodule

// ===== rtl/sonar_reply_frame_parser.sv =====
// A frame's last accepted byte is held in the input register before its result is registered.
// Throughput: one byte per cycle while no held result sees rsp_stall, set by the combinational
// decode between the registers; a held result does not block the input register until it is full.
// Reset is synchronous and active high; it clears the frame state, the valid flags of both
// registers and the configuration (hit threshold 0, head-data code 2).
`timescale 1ns / 1ps

module sonar_reply_frame_parser import srfp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_frame_status,
   output logic [7:0]       rsp_message_code,
   output logic [7:0]       rsp_source_node,
   output logic [7:0]       rsp_dest_node,
   output logic [7:0]       rsp_msg_byte_count,
   output logic             rsp_is_head_data,
   output logic [15:0]      rsp_head_bearing,
   output logic             rsp_hit_found,
   output logic [BIN_W-1:0] rsp_first_hit_bin,
   output logic [BIN_W-1:0] rsp_bin_total,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic [7:0] thr_ff, thr_in;
   logic [7:0] code_ff, code_in;

   logic       advance;
   logic       accept;
   logic       core_valid;
   result_type core_result;

   srfp_frame_core #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .rx_byte       (in_byte_ff),
      .hit_threshold (thr_ff),
      .head_data_code(code_ff),
      .result_valid  (core_valid),
      .result        (core_result)
   );

   always_comb begin
      advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !advance;
      accept = req_valid && !req_stall;

      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in = accept ? req_rx_byte : in_byte_ff;

      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance && core_valid) begin
         out_valid_in = 1'b1;
         out_in = core_result;
      end

      thr_in = thr_ff;
      code_in = code_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HIT_THRESHOLD:  thr_in = csr_wdata;
            CSR_HEAD_DATA_CODE: code_in = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         thr_ff <= 8'd0;
         code_ff <= 8'd2;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         thr_ff <= thr_in;
         code_ff <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_frame_status = out_ff.frame_status;
   assign rsp_message_code = out_ff.message_code;
   assign rsp_source_node = out_ff.source_node;
   assign rsp_dest_node = out_ff.dest_node;
   assign rsp_msg_byte_count = out_ff.msg_byte_count;
   assign rsp_is_head_data = out_ff.is_head_data;
   assign rsp_head_bearing = out_ff.head_bearing;
   assign rsp_hit_found = out_ff.hit_found;
   assign rsp_first_hit_bin = out_ff.first_hit_bin;
   assign rsp_bin_total = out_ff.bin_total;

endmodule

// ===== bench/sonar_reply_frame_parser_tb.sv =====
// Self-checking testbench for the sonar reply frame parser.
`timescale 1ns / 1ps

module sonar_reply_frame_parser_tb;
   import srfp_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   class reply_scoreboard;
      logic [7:0]       threshold;
      logic [7:0]       head_code;
      bit               in_frame;
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] frame_len;
      logic [7:0]       len_low;
      logic [7:0]       src;
      logic [7:0]       dst;
      logic [7:0]       count;
      logic [7:0]       code;
      logic [15:0]      bearing;
      bit               hit;
      logic [BIN_W-1:0] hit_bin;
      result_type       replies_due[$];
      int               predicted;
      int               mismatches;

      function new();
         threshold = 8'd0;
         head_code = 8'd2;
         in_frame = 1'b0;
         predicted = 0;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos = '0;
         frame_len = '0;
         len_low = '0;
         src = '0;
         dst = '0;
         count = '0;
         code = '0;
         bearing = '0;
         hit = 1'b0;
         hit_bin = '0;
      endfunction

      function void set_reg(input logic index, input logic [7:0] value);
         if (index == CSR_HIT_THRESHOLD) begin
            threshold = value;
         end else begin
            head_code = value;
         end
      endfunction

      // Advances the frame state by one accepted byte and queues any reply it completes.
      function void take_byte(input logic [7:0] b);
         result_type r;
         int         total;
         r = '0;
         if (!in_frame) begin
            if (b == HDR_BYTE) begin
               clear_frame();
               in_frame = 1'b1;
            end
            return;
         end
         pos = pos + 1'b1;
         if (pos == POS_LEN_LO) len_low = b;
         if (pos == POS_LEN_HI) begin
            frame_len = {1'b0, b, len_low} + LEN_OVERHEAD;
            if (int'(frame_len) > MAX_FRAME_BYTES_DEF) begin
               r.frame_status = STATUS_OVERSIZE;
               replies_due = {replies_due, r};
               predicted++;
               in_frame = 1'b0;
               return;
            end
         end
         if (pos >= POS_LEN_HI && int'(pos) + 1 >= int'(frame_len)) begin
            r.frame_status = (b == TERM_BYTE) ? STATUS_GOOD : STATUS_BAD_TERM;
            r.message_code = code;
            r.source_node = src;
            r.dest_node = dst;
            r.msg_byte_count = count;
            r.is_head_data = (b == TERM_BYTE) && (code == head_code);
            if (r.is_head_data) begin
               total = (pos > FIRST_BIN_POS) ? int'(pos - FIRST_BIN_POS) : 0;
               if (total > int'(BIN_SAT)) total = int'(BIN_SAT);
               r.head_bearing = bearing;
               r.hit_found = hit;
               r.first_hit_bin = hit ? hit_bin : '0;
               r.bin_total = total[BIN_W-1:0];
            end
            replies_due = {replies_due, r};
            predicted++;
            in_frame = 1'b0;
            return;
         end
         case (pos)
            POS_SRC: src = b;
            POS_DST: dst = b;
            POS_COUNT: count = b;
            POS_CODE: code = b;
            POS_BEAR_LO: bearing[7:0] = b;
            POS_BEAR_HI: bearing[15:8] = b;
            default: ;
         endcase
         if (pos >= FIRST_BIN_POS && !hit && b >= threshold) begin
            total = int'(pos - FIRST_BIN_POS);
            hit = 1'b1;
            hit_bin = (total > int'(BIN_SAT)) ? BIN_SAT : total[BIN_W-1:0];
         end
      endfunction

      function string show(input result_type r);
         return $sformatf({"status=%0d code=%02h src=%02h dst=%02h count=%02h head=%0b ",
                           "bearing=%04h hit=%0b first_bin=%0d bins=%0d"},
                          r.frame_status, r.message_code, r.source_node, r.dest_node,
                          r.msg_byte_count, r.is_head_data, r.head_bearing, r.hit_found,
                          r.first_hit_bin, r.bin_total);
      endfunction

      function void complain(input string what, input string want, input string got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("   expected: %s", want);
            $display("   actual:   %s", got);
         end
      endfunction

      function void check_reply(input result_type got);
         result_type want;
         if (replies_due.size() == 0) begin
            complain("reply with none outstanding", "none", show(got));
            return;
         end
         want = replies_due.pop_front();
         if (got !== want) complain("reply mismatch", show(want), show(got));
      endfunction

      function int close_out();
         while (replies_due.size() != 0) begin
            complain("reply never arrived", show(replies_due.pop_front()), "none");
         end
         return mismatches;
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_rx_byte = 8'd0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [1:0]       rsp_frame_status;
   logic [7:0]       rsp_message_code;
   logic [7:0]       rsp_source_node;
   logic [7:0]       rsp_dest_node;
   logic [7:0]       rsp_msg_byte_count;
   logic             rsp_is_head_data;
   logic [15:0]      rsp_head_bearing;
   logic             rsp_hit_found;
   logic [BIN_W-1:0] rsp_first_hit_bin;
   logic [BIN_W-1:0] rsp_bin_total;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = CSR_HIT_THRESHOLD;
   logic [7:0]       csr_wdata = 8'd0;

   result_type       observed;
   reply_scoreboard  board;
   bit               req_gaps = 1'b1;
   bit               rsp_gaps = 1'b1;
   int               stall_left = 0;
   int               cycles = 0;
   int               frame_bytes = 0;
   logic [7:0]       cur_thr = 8'd0;
   logic [7:0]       cur_code = 8'd2;

   sonar_reply_frame_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_message_code   (rsp_message_code),
      .rsp_source_node    (rsp_source_node),
      .rsp_dest_node      (rsp_dest_node),
      .rsp_msg_byte_count (rsp_msg_byte_count),
      .rsp_is_head_data   (rsp_is_head_data),
      .rsp_head_bearing   (rsp_head_bearing),
      .rsp_hit_found      (rsp_hit_found),
      .rsp_first_hit_bin  (rsp_first_hit_bin),
      .rsp_bin_total      (rsp_bin_total),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   assign observed = {rsp_frame_status, rsp_message_code, rsp_source_node, rsp_dest_node,
                      rsp_msg_byte_count, rsp_is_head_data, rsp_head_bearing, rsp_hit_found,
                      rsp_first_hit_bin, rsp_bin_total};

   always #6 clock = ~clock;

   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_gaps && $urandom_range(0, 99) < 30) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_gap(1'b1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Handshake signals are settled at the falling edge; the transaction completes at the next rise.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_reply(observed);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(req_gaps);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      board.take_byte(b);
   endtask

   task automatic send_frame(input int len, input logic [7:0] code, input logic [7:0] src,
                             input int bin_mode, input bit good_term, input bit truncate);
      logic [7:0] fr[$];
      logic [7:0] v;
      int         last;
      int         hit_at;
      int         cut;
      fr = {fr, HDR_BYTE};
      repeat (4) fr = {fr, rand_byte()};
      fr = {fr, len[7:0]};
      fr = {fr, len[15:8]};
      if (len + 6 > MAX_FRAME_BYTES_DEF || len + 5 < 6) begin
         last = 6;
      end else begin
         last = len + 5;
      end
      hit_at = $urandom_range(44, (last > 45) ? last - 1 : 44);
      for (int p = 7; p <= last; p++) begin
         if (p == last) begin
            v = rand_byte();
            if (v == TERM_BYTE) v = ~v;
            if (good_term) v = TERM_BYTE;
         end else if (p == 7) begin
            v = src;
         end else if (p == 10) begin
            v = code;
         end else if (p >= 44 && bin_mode != 0 && cur_thr != 8'd0) begin
            v = 8'($urandom_range(0, cur_thr - 1));
            if (bin_mode == 2 && p == hit_at) v = 8'($urandom_range(cur_thr, 255));
         end else begin
            v = rand_byte();
         end
         fr = {fr, v};
      end
      if (truncate && fr.size() > 3) begin
         cut = $urandom_range(2, fr.size() - 1);
         while (fr.size() > cut) void'(fr.pop_back());
      end
      foreach (fr[i]) send_byte(fr[i]);
      frame_bytes += fr.size();
   endtask

   // Completes any open frame, then waits until every reply is in and the pipeline is empty.
   task automatic settle();
      while (board.in_frame) send_byte(TERM_BYTE);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.replies_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] thr, input logic [7:0] code);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HIT_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      board.set_reg(CSR_HIT_THRESHOLD, thr);
      csr_index <= CSR_HEAD_DATA_CODE;
      csr_wdata <= code;
      @(posedge clock);
      board.set_reg(CSR_HEAD_DATA_CODE, code);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cur_thr = thr;
      cur_code = code;
   endtask

   task automatic random_item();
      int         pick;
      int         len;
      logic [7:0] code;
      pick = $urandom_range(0, 99);
      code = ($urandom_range(0, 99) < 65) ? cur_code : rand_byte();
      if (pick < 8) begin
         repeat ($urandom_range(1, 6)) send_byte(rand_byte());
      end else if (pick < 13) begin
         len = ($urandom_range(0, 1) == 0) ? MAX_FRAME_BYTES_DEF - 5 : $urandom_range(507, 65535);
         send_frame(len, code, rand_byte(), 0, 1'b1, 1'b0);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = $urandom_range(40, 64);
         end else if (pick < 85) begin
            len = $urandom_range(0, 39);
         end else begin
            len = $urandom_range(65, 140);
         end
         send_frame(len, code, rand_byte(), $urandom_range(0, 2),
                    $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
      end
   endtask

   initial begin
      int         start_bytes;
      logic [7:0] thr;
      logic [7:0] code;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(TERM_BYTE);
      send_frame(60, 8'd2, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(20, 8'h07, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(50, 8'd2, rand_byte(), 0, 1'b0, 1'b0);
      send_frame(0, 8'd2, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(1, 8'd2, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(2, 8'd2, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(4, 8'd2, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(MAX_FRAME_BYTES_DEF - 5, 8'd2, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(65535, 8'd2, rand_byte(), 0, 1'b1, 1'b0);
      send_frame(MAX_FRAME_BYTES_DEF - 6, 8'd2, HDR_BYTE, 0, 1'b1, 1'b0);

      write_config(8'd255, 8'd255);
      send_frame(60, 8'd255, rand_byte(), 2, 1'b1, 1'b0);
      send_frame(60, 8'd255, rand_byte(), 1, 1'b1, 1'b0);
      send_frame(34, 8'd255, rand_byte(), 2, 1'b1, 1'b0);
      send_frame(36, 8'd255, rand_byte(), 2, 1'b1, 1'b0);
      send_frame(38, 8'd255, rand_byte(), 2, 1'b1, 1'b0);
      send_frame(39, 8'd255, rand_byte(), 2, 1'b1, 1'b0);
      send_frame(40, 8'd255, rand_byte(), 2, 1'b1, 1'b0);

      write_config(8'd200, 8'd0);
      send_frame(45, 8'd0, rand_byte(), 2, 1'b1, 1'b0);
      send_frame(50, 8'd0, rand_byte(), 1, 1'b1, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin thr = 8'd0;       code = 8'd2;       end
            1: begin thr = 8'd255;     code = 8'd0;       end
            2: begin thr = rand_byte(); code = 8'd255;    end
            3: begin thr = 8'd128;     code = rand_byte(); end
            4: begin thr = rand_byte(); code = rand_byte(); end
            default: begin thr = 8'd1; code = 8'd2;       end
         endcase
         write_config(thr, code);
         req_gaps = (ph != 2 && ph != 4);
         rsp_gaps = (ph != 3 && ph != 4);
         start_bytes = frame_bytes;
         while (frame_bytes - start_bytes < 25) begin
            random_item();
         end
      end

      settle();
      repeat (12) @(posedge clock);
      if (board.close_out() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
